// ===== rtl/core/lmts_pkg.sv =====
// Shared types and constants of the LCD mode timing sequencer.
package lmts_pkg;

  // Field widths fixed by the item and result formats.
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned LINE_W    = 8;
  localparam int unsigned BUDGET_W  = 12;
  localparam int unsigned STAT_EN_W = 3;

  // Bit positions in the STAT source enable register.
  localparam int unsigned STAT_EN_HBLANK = 0;
  localparam int unsigned STAT_EN_VBLANK = 1;
  localparam int unsigned STAT_EN_SEARCH = 2;

  // Cycle cost of each mode, loaded into the budget on mode entry.
  localparam logic [BUDGET_W-1:0] COST_HBLANK = 12'd204;
  localparam logic [BUDGET_W-1:0] COST_VBLANK = 12'd456;
  localparam logic [BUDGET_W-1:0] COST_SEARCH = 12'd80;
  localparam logic [BUDGET_W-1:0] COST_DRAW   = 12'd172;

  // Most negative budget value; the budget saturates here.
  localparam logic [BUDGET_W-1:0] BUDGET_MIN = 12'h800;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  // Timing state carried from one word to the next.
  typedef struct packed {
    mode_e                      mode;
    logic [LINE_W-1:0]          line;
    logic signed [BUDGET_W-1:0] budget;
  } timing_state_t;

  // Per-word request and event pulses.
  typedef struct packed {
    logic vblank_request;
    logic stat_request;
    logic line_changed;
    logic oam_search;
    logic draw_line;
    logic frame_done;
    logic hdma_tick;
  } timing_events_t;

endpackage

// ===== rtl/core/lmts_item_if.sv =====
// Input channel: elapsed cycle count and LCD enable, with valid/ready.
interface lmts_item_if;
  logic                           valid;
  logic                           ready;
  logic [lmts_pkg::ELAPSED_W-1:0] elapsed_cycles;
  logic                           lcd_on;

  modport source (output valid, output elapsed_cycles, output lcd_on, input ready);
  modport sink   (input valid, input elapsed_cycles, input lcd_on, output ready);
endinterface

// ===== rtl/core/lmts_result_if.sv =====
// Output channel: mode, line and event pulses, with valid/ready.
interface lmts_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [lmts_pkg::LINE_W-1:0] line;
  logic                        vblank_request;
  logic                        stat_request;
  logic                        line_changed;
  logic                        oam_search;
  logic                        draw_line;
  logic                        frame_done;
  logic                        hdma_tick;

  modport source (
    output valid, output mode, output line, output vblank_request, output stat_request,
    output line_changed, output oam_search, output draw_line, output frame_done,
    output hdma_tick, input ready
  );
  modport sink (
    input valid, input mode, input line, input vblank_request, input stat_request,
    input line_changed, input oam_search, input draw_line, input frame_done,
    input hdma_tick, output ready
  );
endinterface

// ===== rtl/core/lmts_step.sv =====
// Combinational mode transition: budget subtract, mode change and event pulses.
module lmts_step #(
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned LAST_LINE     = 153
) (
  input  lmts_pkg::timing_state_t        cur_i,
  input  logic [lmts_pkg::ELAPSED_W-1:0] elapsed_i,
  input  logic                           lcd_on_i,
  input  logic [lmts_pkg::STAT_EN_W-1:0] stat_en_i,
  output lmts_pkg::timing_state_t        nxt_o,
  output lmts_pkg::timing_events_t       ev_o
);

  localparam logic [lmts_pkg::LINE_W-1:0] VisLine  = lmts_pkg::LINE_W'(VISIBLE_LINES);
  localparam logic [lmts_pkg::LINE_W:0]   LastLine = (lmts_pkg::LINE_W + 1)'(LAST_LINE);

  logic [lmts_pkg::BUDGET_W:0]   diff;
  logic [lmts_pkg::BUDGET_W:0]   carry;
  logic [lmts_pkg::LINE_W-1:0]   line_inc;
  logic [lmts_pkg::LINE_W:0]     line_next;

  // Budget after this word, one bit wider so the sign survives the subtract.
  assign diff      = {cur_i.budget[lmts_pkg::BUDGET_W-1], cur_i.budget}
                   - {3'b000, elapsed_i};
  assign carry     = diff + {1'b0, lmts_pkg::COST_VBLANK};
  assign line_inc  = cur_i.line + 1'b1;
  assign line_next = {1'b0, cur_i.line} + 1'b1;

  always_comb begin
    nxt_o = cur_i;
    ev_o  = '0;
    if (!lcd_on_i) begin
      // With the LCD off the budget holds, and line and mode go to zero.
      nxt_o.mode = lmts_pkg::MODE_HBLANK;
      nxt_o.line = '0;
    end else begin
      nxt_o.budget = diff[lmts_pkg::BUDGET_W-1:0];
      // Budget used up (zero or negative): exactly one mode step.
      if (diff[lmts_pkg::BUDGET_W] || (diff == '0)) begin
        unique case (cur_i.mode)
          lmts_pkg::MODE_HBLANK: begin
            nxt_o.line        = line_inc;
            ev_o.line_changed = 1'b1;
            ev_o.hdma_tick    = 1'b1;
            if (line_inc >= VisLine) begin
              ev_o.vblank_request = 1'b1;
              ev_o.stat_request   = stat_en_i[lmts_pkg::STAT_EN_VBLANK];
              nxt_o.mode          = lmts_pkg::MODE_VBLANK;
              nxt_o.budget        = lmts_pkg::COST_VBLANK;
            end else begin
              ev_o.stat_request = stat_en_i[lmts_pkg::STAT_EN_SEARCH];
              nxt_o.mode        = lmts_pkg::MODE_SEARCH;
              nxt_o.budget      = lmts_pkg::COST_SEARCH;
            end
          end
          lmts_pkg::MODE_VBLANK: begin
            ev_o.line_changed = 1'b1;
            if (line_next > LastLine) begin
              nxt_o.line        = '0;
              ev_o.frame_done   = 1'b1;
              ev_o.stat_request = stat_en_i[lmts_pkg::STAT_EN_SEARCH];
              nxt_o.mode        = lmts_pkg::MODE_SEARCH;
              nxt_o.budget      = lmts_pkg::COST_SEARCH;
            end else begin
              // Staying in vblank keeps the carry, saturating at the minimum.
              nxt_o.line = line_next[lmts_pkg::LINE_W-1:0];
              if (carry[lmts_pkg::BUDGET_W] && !carry[lmts_pkg::BUDGET_W-1]) begin
                nxt_o.budget = lmts_pkg::BUDGET_MIN;
              end else begin
                nxt_o.budget = carry[lmts_pkg::BUDGET_W-1:0];
              end
            end
          end
          lmts_pkg::MODE_SEARCH: begin
            ev_o.oam_search = 1'b1;
            nxt_o.mode      = lmts_pkg::MODE_DRAW;
            nxt_o.budget    = lmts_pkg::COST_DRAW;
          end
          lmts_pkg::MODE_DRAW: begin
            ev_o.draw_line    = (cur_i.line < VisLine);
            ev_o.stat_request = stat_en_i[lmts_pkg::STAT_EN_HBLANK];
            nxt_o.mode        = lmts_pkg::MODE_HBLANK;
            nxt_o.budget      = lmts_pkg::COST_HBLANK;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/lcd_mode_timing_sequencer_core.sv =====
// Top level of the LCD mode timing sequencer: input register, state and result register.
// The sequencer takes one word per clock and presents one result word for each: a word
// lands in the input register, the transition logic runs against the mode, line and
// budget registers, and the result register is loaded at the same edge at which the
// state updates. Throughput is one word per cycle as long as the result side takes
// words; the result register holds a stalled word while the input register still
// accepts one more. Write the STAT source enables only while no word is in flight.
module lcd_mode_timing_sequencer_core #(
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned LAST_LINE     = 153
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmts_pkg::STAT_EN_W-1:0] cfg_wdata_i,
  lmts_item_if.sink                      item_i,
  lmts_result_if.source                  result_o
);

  logic                           in_valid_q;
  logic [lmts_pkg::ELAPSED_W-1:0] elapsed_q;
  logic                           lcd_on_q;
  logic [lmts_pkg::STAT_EN_W-1:0] stat_en_q;
  lmts_pkg::timing_state_t        state_q;
  lmts_pkg::timing_state_t        state_d;
  lmts_pkg::timing_events_t       ev_d;
  lmts_pkg::timing_events_t       ev_q;
  logic                           out_valid_q;
  logic                           advance;
  logic                           take;

  // The result register frees up when empty or when its word is taken.
  assign advance      = !out_valid_q || result_o.ready;
  assign take         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || take;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_en_q <= '0;
    end else if (cfg_we_i) begin
      stat_en_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      elapsed_q <= item_i.elapsed_cycles;
      lcd_on_q  <= item_i.lcd_on;
    end
  end

  // Transition logic.
  lmts_step #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cur_i     (state_q),
    .elapsed_i (elapsed_q),
    .lcd_on_i  (lcd_on_q),
    .stat_en_i (stat_en_q),
    .nxt_o     (state_d),
    .ev_o      (ev_d)
  );

  // Timing state advances once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= lmts_pkg::MODE_HBLANK;
      state_q.line   <= '0;
      state_q.budget <= '0;
    end else if (take) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q <= ev_d;
    end
  end

  // The result shows the state as it stands after its word.
  assign result_o.valid          = out_valid_q;
  assign result_o.mode           = state_q.mode;
  assign result_o.line           = state_q.line;
  assign result_o.vblank_request = ev_q.vblank_request;
  assign result_o.stat_request   = ev_q.stat_request;
  assign result_o.line_changed   = ev_q.line_changed;
  assign result_o.oam_search     = ev_q.oam_search;
  assign result_o.draw_line      = ev_q.draw_line;
  assign result_o.frame_done     = ev_q.frame_done;
  assign result_o.hdma_tick      = ev_q.hdma_tick;

endmodule

// ===== rtl/core/lmts_checker.sv =====
// Port-level checks of the LCD mode timing sequencer, bound to the top level.
module lmts_checker #(
  parameter int unsigned LAST_LINE = 153
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  mode_i,
  input logic [lmts_pkg::LINE_W-1:0] line_i,
  input logic                        vblank_request_i,
  input logic                        stat_request_i,
  input logic                        line_changed_i,
  input logic                        frame_done_i,
  input logic                        hdma_tick_i
);

  localparam logic [lmts_pkg::LINE_W:0] LastLine = (lmts_pkg::LINE_W + 1)'(LAST_LINE);

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mode_i) && $stable(line_i))
    else $error("stalled result word changed");

  // The line never passes the last line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, line_i} <= LastLine))
    else $error("line beyond last line");

  // A finished frame restarts at line zero in search mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |->
      (line_i == '0) && (mode_i == lmts_pkg::MODE_SEARCH) && line_changed_i)
    else $error("frame done without wrap to search");

  // A DMA tick only comes with the end of hblank, which always moves the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hdma_tick_i |->
      line_changed_i && (mode_i != lmts_pkg::MODE_HBLANK) && (mode_i != lmts_pkg::MODE_DRAW))
    else $error("DMA tick outside hblank exit");

  // A STAT request only comes with entry into hblank, search or vblank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stat_request_i |->
      (mode_i == lmts_pkg::MODE_HBLANK) || (mode_i == lmts_pkg::MODE_SEARCH) ||
      vblank_request_i)
    else $error("STAT request without mode entry");

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker #(
  .LAST_LINE (LAST_LINE)
) u_lmts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .mode_i           (result_o.mode),
  .line_i           (result_o.line),
  .vblank_request_i (result_o.vblank_request),
  .stat_request_i   (result_o.stat_request),
  .line_changed_i   (result_o.line_changed),
  .frame_done_i     (result_o.frame_done),
  .hdma_tick_i      (result_o.hdma_tick)
);

// ===== bench/lcd_mode_timing_sequencer_core_test.sv =====
// Self-checking testbench for the LCD mode timing sequencer with a predicting scoreboard.
module lcd_mode_timing_sequencer_core_test;

  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;
  localparam int MAX_REPORTS   = 10;

  // One result word as the sequencer returns it; events are ordered vblank first, hdma last.
  typedef struct packed {
    lmts_pkg::mode_e                 mode;
    logic [lmts_pkg::LINE_W-1:0]     line;
    lmts_pkg::timing_events_t        ev;
  } timing_result_t;

  // Scoreboard: tracks mode, line and budget, and queues the result each word must cause.
  class timing_scoreboard;
    lmts_pkg::mode_e                cur_mode;
    logic [lmts_pkg::LINE_W-1:0]    cur_line;
    int                             budget;
    logic [lmts_pkg::STAT_EN_W-1:0] stat_en;
    int                             visible_lines;
    int                             last_line;
    int                             budget_floor;
    int                             failures;
    timing_result_t                 pending_results[$];

    function new(int vis_lines, int wrap_line);
      visible_lines = vis_lines;
      last_line     = wrap_line;
      budget_floor  = -(1 << (int'(lmts_pkg::BUDGET_W) - 1));
      failures      = 0;
      cur_mode      = lmts_pkg::MODE_HBLANK;
      cur_line      = '0;
      budget        = 0;
      stat_en       = '0;
    endfunction

    function void set_enables(logic [lmts_pkg::STAT_EN_W-1:0] value);
      stat_en = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the timing state by one accepted word and queue the result it causes.
    function void note_word(logic [lmts_pkg::ELAPSED_W-1:0] elapsed, logic lcd_on);
      timing_result_t r;
      int             b;
      int             next_line;
      r = '0;
      if (!lcd_on) begin
        // LCD off parks the sequencer on line 0 in hblank; the budget is held.
        cur_mode = lmts_pkg::MODE_HBLANK;
        cur_line = '0;
      end else begin
        b = budget - int'(elapsed);
        // At most one mode change per word, however many cycles have passed.
        if (b <= 0) begin
          case (cur_mode)
            lmts_pkg::MODE_HBLANK: begin
              cur_line = cur_line + 8'd1;
              r.ev.line_changed = 1'b1;
              r.ev.hdma_tick    = 1'b1;
              if (int'(cur_line) >= visible_lines) begin
                r.ev.vblank_request = 1'b1;
                r.ev.stat_request   = stat_en[lmts_pkg::STAT_EN_VBLANK];
                cur_mode = lmts_pkg::MODE_VBLANK;
                b = int'(lmts_pkg::COST_VBLANK);
              end else begin
                r.ev.stat_request = stat_en[lmts_pkg::STAT_EN_SEARCH];
                cur_mode = lmts_pkg::MODE_SEARCH;
                b = int'(lmts_pkg::COST_SEARCH);
              end
            end
            lmts_pkg::MODE_VBLANK: begin
              // Vblank keeps the carry; the wrap check runs at full precision.
              next_line = int'(cur_line) + 1;
              r.ev.line_changed = 1'b1;
              b = b + int'(lmts_pkg::COST_VBLANK);
              if (next_line > last_line) begin
                cur_line = '0;
                r.ev.frame_done   = 1'b1;
                r.ev.stat_request = stat_en[lmts_pkg::STAT_EN_SEARCH];
                cur_mode = lmts_pkg::MODE_SEARCH;
                b = int'(lmts_pkg::COST_SEARCH);
              end else begin
                cur_line = next_line[lmts_pkg::LINE_W-1:0];
              end
            end
            lmts_pkg::MODE_SEARCH: begin
              r.ev.oam_search = 1'b1;
              cur_mode = lmts_pkg::MODE_DRAW;
              b = int'(lmts_pkg::COST_DRAW);
            end
            default: begin
              r.ev.draw_line    = (int'(cur_line) < visible_lines);
              r.ev.stat_request = stat_en[lmts_pkg::STAT_EN_HBLANK];
              cur_mode = lmts_pkg::MODE_HBLANK;
              b = int'(lmts_pkg::COST_HBLANK);
            end
          endcase
        end
        // The budget saturates at the most negative 12-bit value.
        if (b < budget_floor) begin
          b = budget_floor;
        end
        budget = b;
      end
      r.mode = cur_mode;
      r.line = cur_line;
      pending_results.push_back(r);
    endfunction

    // Compare one returned word with the oldest expectation.
    function void check_result(timing_result_t got);
      timing_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected result word: mode %0d line %0d events %b",
                   got.mode, got.line, got.ev);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.mode !== want.mode || got.line !== want.line || got.ev !== want.ev) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result mismatch: expected mode %0d line %0d events %b,",
                   want.mode, want.line, want.ev,
                   " got mode %0d line %0d events %b", got.mode, got.line, got.ev);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [lmts_pkg::STAT_EN_W-1:0] cfg_wdata_i;
  int                             words_sent;
  int                             results_seen;
  timing_scoreboard               sb;

  lmts_item_if   item_bus ();
  lmts_result_if result_bus ();

  lcd_mode_timing_sequencer_core #(
    .VISIBLE_LINES(VISIBLE_LINES),
    .LAST_LINE    (LAST_LINE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always #5 clk_i = ~clk_i;

  // Offer one word, with random idle cycles outside the quiet window, and note it on acceptance.
  task automatic send_word(input logic [lmts_pkg::ELAPSED_W-1:0] elapsed, input logic lcd_on);
    if (!(words_sent >= 600 && words_sent < 900)) begin
      while ($urandom_range(99) < 17) begin
        item_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    item_bus.valid          <= 1'b1;
    item_bus.elapsed_cycles <= elapsed;
    item_bus.lcd_on         <= lcd_on;
    do @(posedge clk_i); while (!item_bus.ready);
    sb.note_word(elapsed, lcd_on);
    words_sent++;
  endtask

  // Frame runs keep the LCD on with mostly large steps so that whole frames go by.
  task automatic send_random_word(input bit frame_run);
    logic [lmts_pkg::ELAPSED_W-1:0] elapsed;
    logic                           lcd_on;
    int                             pick;
    pick   = $urandom_range(99);
    lcd_on = 1'b1;
    if (sb.cur_mode == lmts_pkg::MODE_VBLANK && pick < 60) begin
      // Long steps through vblank drive the budget down to its floor.
      elapsed = '1;
    end else if (frame_run) begin
      if (pick < 75) begin
        elapsed = lmts_pkg::ELAPSED_W'($urandom_range(1023, 256));
      end else begin
        elapsed = lmts_pkg::ELAPSED_W'($urandom_range(255, 0));
      end
    end else begin
      elapsed = lmts_pkg::ELAPSED_W'($urandom_range(1023, 0));
      lcd_on  = ($urandom_range(99) >= 15);
    end
    send_word(elapsed, lcd_on);
  endtask

  // Wait until every expected word has come back, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stat_enables(input logic [lmts_pkg::STAT_EN_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.set_enables(value);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [lmts_pkg::STAT_EN_W-1:0] enables, input int count,
                           input bit frame_run);
    wait_drained();
    write_stat_enables(enables);
    for (int n = 0; n < count; n++) begin
      send_random_word(frame_run);
    end
    item_bus.valid <= 1'b0;
  endtask

  // Main sequence: reset, directed words, then random phases under different enables.
  initial begin
    sb = new(VISIBLE_LINES, LAST_LINE);
    words_sent              = 0;
    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_wdata_i             <= '0;
    item_bus.valid          <= 1'b0;
    item_bus.elapsed_cycles <= '0;
    item_bus.lcd_on         <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // LCD off with both extremes of the step size.
    send_word(10'd0, 1'b0);
    send_word(10'd1023, 1'b0);
    // A zero budget moves on even with no cycles elapsed.
    send_word(10'd0, 1'b1);
    send_word(10'd0, 1'b1);
    // Budget reaching exactly zero, then a huge step that still makes one change only.
    send_word(10'd80, 1'b1);
    send_word(10'd1023, 1'b1);
    send_word(10'd203, 1'b1);
    send_word(10'd1, 1'b1);
    send_word(10'd79, 1'b1);
    send_word(10'd1, 1'b1);
    send_word(10'd171, 1'b1);
    send_word(10'd1, 1'b1);
    send_word(10'd512, 1'b1);
    // LCD off mid-line holds the budget and parks on line 0.
    send_word(10'd5, 1'b0);
    send_word(10'd341, 1'b1);
    send_word(10'd682, 1'b1);
    send_word(10'd1023, 1'b1);
    send_word(10'd0, 1'b1);
    send_word(10'd1023, 1'b1);
    send_word(10'd1023, 1'b1);
    item_bus.valid <= 1'b0;

    run_phase(3'd7, 800, 1'b1);
    run_phase(3'd0, 300, 1'b0);
    run_phase(3'd2, 600, 1'b1);
    run_phase(3'd5, 250, 1'b0);

    wait_drained();
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, a quiet window, and long hold-offs that back up the input.
  initial begin
    int hold_left;
    int next_hold_at;
    hold_left    = 0;
    next_hold_at = 250;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left    = 80;
        next_hold_at = next_hold_at + 900;
      end
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 600 && results_seen < 900) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Check every result word accepted at a clock edge.
  initial results_seen = 0;
  always @(posedge clk_i) begin : result_monitor
    timing_result_t got;
    if (rst_ni === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      got.mode = lmts_pkg::mode_e'(result_bus.mode);
      got.line = result_bus.line;
      got.ev   = {result_bus.vblank_request, result_bus.stat_request, result_bus.line_changed,
                  result_bus.oam_search, result_bus.draw_line, result_bus.frame_done,
                  result_bus.hdma_tick};
      sb.check_result(got);
      results_seen++;
    end
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
